// ===== hw/rtl/bcmc_pkg.sv =====
// Shared types, register indexes and constants of the charge mode controller.
package bcmc_pkg;

  localparam int unsigned CellCount  = 4;
  localparam int unsigned MvW        = 13;
  localparam int unsigned MaW        = 18;
  localparam int unsigned CurW       = 19;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 18;
  localparam int unsigned InDataW    = 112;
  localparam int unsigned OutDataW   = 16;

  // Fixed thresholds of the balancing rules
  localparam logic [MvW-1:0] BalanceStartMv  = 13'd4100;
  localparam logic [MvW-1:0] BalanceWindowMv = 13'd10;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegFaultMasks    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegDeepSleepMv   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegRecoveryMv    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegRechargeMv    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegFullMv        = 3'd4;
  localparam logic [CfgIdxW-1:0] RegMaxDeltaMv    = 3'd5;
  localparam logic [CfgIdxW-1:0] RegNoiseFloorMa  = 3'd6;
  localparam logic [CfgIdxW-1:0] RegTailCurrentMa = 3'd7;

  // Register reset values
  localparam logic [15:0]    FaultMasksRst    = 16'hF00F;
  localparam logic [MvW-1:0] DeepSleepMvRst   = 13'd2800;
  localparam logic [MvW-1:0] RecoveryMvRst    = 13'd3000;
  localparam logic [MvW-1:0] RechargeMvRst    = 13'd4000;
  localparam logic [MvW-1:0] FullMvRst        = 13'd4150;
  localparam logic [MvW-1:0] MaxDeltaMvRst    = 13'd30;
  localparam logic [MaW-1:0] NoiseFloorMaRst  = 18'd100;
  localparam logic [MaW-1:0] TailCurrentMaRst = 18'd200;

  typedef enum logic [3:0] {
    ModeBoot        = 4'd0,
    ModeIdle        = 4'd1,
    ModeFullIdle    = 4'd2,
    ModeRecovery    = 4'd3,
    ModeBulk        = 4'd4,
    ModeBalancing   = 4'd5,
    ModeDischarging = 4'd6,
    ModeSleep       = 4'd7,
    ModeLimp        = 4'd8,
    ModeFault       = 4'd9
  } mode_e;

  typedef struct packed {
    logic [15:0]    fault_masks;
    logic [MvW-1:0] deep_sleep_mv;
    logic [MvW-1:0] recovery_limit_mv;
    logic [MvW-1:0] recharge_mv;
    logic [MvW-1:0] full_mv;
    logic [MvW-1:0] max_delta_mv;
    logic [MaW-1:0] noise_floor_ma;
    logic [MaW-1:0] tail_current_ma;
  } cfg_t;

  typedef struct packed {
    logic [7:0]                 fault_flags;
    logic [MvW-1:0]             min_cell_mv;
    logic [MvW-1:0]             max_cell_mv;
    logic signed [CurW-1:0]     pack_current_ma;
    logic                       charger_present;
    logic [CellCount*MvW-1:0]   cell_voltages_packed;
  } item_t;

  typedef struct packed {
    mode_e          mode;
    logic           charge_relay;
    logic           discharge_relay;
    logic           recovery_relay;
    logic [3:0]     balance_mask;
  } ctrl_t;

endpackage

// ===== hw/rtl/bcmc_rules.sv =====
// Mode transition and relay rules for one measurement snapshot.
module bcmc_rules import bcmc_pkg::*; (
  input  cfg_t  cfg_i,
  input  ctrl_t ctrl_i,
  input  item_t item_i,
  output ctrl_t ctrl_o
);

  logic [7:0]             hard_hit;
  logic [7:0]             soft_hit;
  logic signed [CurW:0]   cur_ext;
  logic [CurW-1:0]        mag;
  logic signed [MvW+1:0]  spread;
  logic                   deep_sleep;
  logic                   below_noise_neg;
  logic                   mag_lt_noise;
  logic                   mag_lt_tail;
  logic                   spread_gt_delta;
  logic                   spread_le_window;
  logic [MvW:0]           bal_limit;
  logic [3:0]             bal_bits;

  // Shared comparisons
  always_comb begin
    hard_hit        = item_i.fault_flags & cfg_i.fault_masks[7:0];
    soft_hit        = item_i.fault_flags & cfg_i.fault_masks[15:8];
    cur_ext         = {item_i.pack_current_ma[CurW-1], item_i.pack_current_ma};
    mag             = item_i.pack_current_ma[CurW-1] ? CurW'(-cur_ext)
                                                     : item_i.pack_current_ma;
    spread          = $signed({2'b00, item_i.max_cell_mv}) -
                      $signed({2'b00, item_i.min_cell_mv});
    deep_sleep      = (item_i.min_cell_mv <= cfg_i.deep_sleep_mv) &&
                      (ctrl_i.mode != ModeRecovery) && (ctrl_i.mode != ModeBoot);
    below_noise_neg = cur_ext < -$signed({2'b00, cfg_i.noise_floor_ma});
    mag_lt_noise    = mag < {1'b0, cfg_i.noise_floor_ma};
    mag_lt_tail     = mag < {1'b0, cfg_i.tail_current_ma};
    spread_gt_delta = spread > $signed({2'b00, cfg_i.max_delta_mv});
    spread_le_window = spread <= $signed({2'b00, BalanceWindowMv});
    bal_limit       = {1'b0, item_i.min_cell_mv} + {1'b0, BalanceWindowMv};
  end

  // Bleed every cell that sits above the window over the lowest cell
  always_comb begin
    bal_bits = '0;
    for (int i = 0; i < CellCount; i++) begin
      bal_bits[i] = {1'b0, item_i.cell_voltages_packed[i*MvW +: MvW]} > bal_limit;
    end
  end

  // Apply the rules in priority order
  always_comb begin
    ctrl_o = ctrl_i;
    if (hard_hit != '0) begin
      ctrl_o.mode            = ModeFault;
      ctrl_o.charge_relay    = 1'b0;
      ctrl_o.discharge_relay = 1'b0;
      ctrl_o.recovery_relay  = 1'b0;
      ctrl_o.balance_mask    = '0;
    end else if (soft_hit != '0) begin
      ctrl_o.mode            = ModeLimp;
      ctrl_o.charge_relay    = 1'b1;
      ctrl_o.discharge_relay = 1'b1;
      ctrl_o.recovery_relay  = 1'b0;
    end else if (deep_sleep) begin
      ctrl_o.mode            = ModeSleep;
      ctrl_o.charge_relay    = 1'b0;
      ctrl_o.discharge_relay = 1'b0;
      ctrl_o.recovery_relay  = 1'b0;
    end else begin
      unique case (ctrl_i.mode)
        ModeFault, ModeLimp, ModeBoot: begin
          if (item_i.fault_flags == '0) ctrl_o.mode = ModeIdle;
        end
        ModeIdle, ModeFullIdle: begin
          ctrl_o.charge_relay    = 1'b0;
          ctrl_o.discharge_relay = 1'b0;
          ctrl_o.recovery_relay  = 1'b0;
          if (item_i.charger_present) begin
            if (item_i.min_cell_mv < cfg_i.recovery_limit_mv) ctrl_o.mode = ModeRecovery;
            else if (item_i.max_cell_mv < cfg_i.recharge_mv) ctrl_o.mode = ModeBulk;
          end else if (below_noise_neg) begin
            ctrl_o.mode = ModeDischarging;
          end
        end
        ModeRecovery: begin
          ctrl_o.charge_relay   = 1'b0;
          ctrl_o.recovery_relay = 1'b1;
          if (!item_i.charger_present) ctrl_o.mode = ModeIdle;
          else if (item_i.min_cell_mv >= cfg_i.recovery_limit_mv) ctrl_o.mode = ModeBulk;
        end
        ModeBulk: begin
          ctrl_o.charge_relay   = 1'b1;
          ctrl_o.recovery_relay = 1'b0;
          if (!item_i.charger_present) begin
            ctrl_o.mode = ModeIdle;
          end else if (item_i.max_cell_mv >= BalanceStartMv && spread_gt_delta) begin
            ctrl_o.mode = ModeBalancing;
          end else if (item_i.max_cell_mv >= cfg_i.full_mv && mag_lt_tail) begin
            ctrl_o.mode = ModeFullIdle;
          end
        end
        ModeBalancing: begin
          ctrl_o.charge_relay = 1'b1;
          ctrl_o.balance_mask = bal_bits;
          if (!item_i.charger_present) ctrl_o.mode = ModeIdle;
          else if (spread_le_window) ctrl_o.mode = ModeBulk;
        end
        ModeDischarging: begin
          ctrl_o.discharge_relay = 1'b1;
          if (mag_lt_noise) ctrl_o.mode = ModeIdle;
        end
        ModeSleep: begin
          if (item_i.charger_present) ctrl_o.mode = ModeRecovery;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/battery_charge_mode_controller_core.sv =====
// Top level of the battery charge mode controller: stream ports, registers and state.
//
// The block takes one measurement snapshot per cycle while s_axis_tready is high and
// returns one result per snapshot: the new mode, the three relay commands and the
// cell bleed mask. A snapshot is captured in an input register, evaluated against
// the held mode in one short combinational pass, and the updated state is the result
// register that drives the output stream; a snapshot waits in the input register until
// the output side is free. The sustained rate is one item per clock while
// m_axis_tready is high. The input register keeps accepting while one result waits
// on the output side; only when both are full does s_axis_tready drop. Configuration
// registers take effect at once and are meant to be written while no item is in flight.
module battery_charge_mode_controller_core import bcmc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // Measurement snapshots
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // tdata from bit 0: fault_flags[7:0], min_cell_mv[12:0], max_cell_mv[12:0],
  // pack_current_ma[18:0], charger_present, cell_voltages_packed[51:0], 6 zero bits
  input  logic [InDataW-1:0]  s_axis_tdata,
  // Results
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // tdata from bit 0: mode[3:0], charge_relay, discharge_relay, recovery_relay,
  // balance_mask[3:0], 5 zero bits
  output logic [OutDataW-1:0] m_axis_tdata
);

  cfg_t  cfg_q;
  item_t item_q;
  logic  item_valid_q;
  ctrl_t ctrl_q;
  ctrl_t ctrl_d;
  logic  out_valid_q;
  logic  out_free;
  logic  eval_go;
  logic  in_take;
  item_t item_d;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign eval_go       = item_valid_q && out_free;
  assign s_axis_tready = !item_valid_q || out_free;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // Unpack the input stream
  always_comb begin
    item_d.fault_flags          = s_axis_tdata[7:0];
    item_d.min_cell_mv          = s_axis_tdata[20:8];
    item_d.max_cell_mv          = s_axis_tdata[33:21];
    item_d.pack_current_ma      = $signed(s_axis_tdata[52:34]);
    item_d.charger_present      = s_axis_tdata[53];
    item_d.cell_voltages_packed = s_axis_tdata[105:54];
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fault_masks       <= FaultMasksRst;
      cfg_q.deep_sleep_mv     <= DeepSleepMvRst;
      cfg_q.recovery_limit_mv <= RecoveryMvRst;
      cfg_q.recharge_mv       <= RechargeMvRst;
      cfg_q.full_mv           <= FullMvRst;
      cfg_q.max_delta_mv      <= MaxDeltaMvRst;
      cfg_q.noise_floor_ma    <= NoiseFloorMaRst;
      cfg_q.tail_current_ma   <= TailCurrentMaRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegFaultMasks:    cfg_q.fault_masks       <= cfg_data_i[15:0];
        RegDeepSleepMv:   cfg_q.deep_sleep_mv     <= cfg_data_i[MvW-1:0];
        RegRecoveryMv:    cfg_q.recovery_limit_mv <= cfg_data_i[MvW-1:0];
        RegRechargeMv:    cfg_q.recharge_mv       <= cfg_data_i[MvW-1:0];
        RegFullMv:        cfg_q.full_mv           <= cfg_data_i[MvW-1:0];
        RegMaxDeltaMv:    cfg_q.max_delta_mv      <= cfg_data_i[MvW-1:0];
        RegNoiseFloorMa:  cfg_q.noise_floor_ma    <= cfg_data_i[MaW-1:0];
        RegTailCurrentMa: cfg_q.tail_current_ma   <= cfg_data_i[MaW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Capture the snapshot payload
  always_ff @(posedge clk_i) begin
    if (in_take) item_q <= item_d;
  end

  // Evaluate the held snapshot against the current state
  bcmc_rules u_rules (
    .cfg_i  (cfg_q),
    .ctrl_i (ctrl_q),
    .item_i (item_q),
    .ctrl_o (ctrl_d)
  );

  // Hold valid flags and advance the state, which doubles as the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      ctrl_q       <= '{mode: ModeBoot, charge_relay: 1'b0, discharge_relay: 1'b0,
                        recovery_relay: 1'b0, balance_mask: 4'b0};
    end else begin
      if (in_take)       item_valid_q <= 1'b1;
      else if (eval_go)  item_valid_q <= 1'b0;
      if (eval_go) begin
        ctrl_q      <= ctrl_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, ctrl_q.balance_mask, ctrl_q.recovery_relay,
                          ctrl_q.discharge_relay, ctrl_q.charge_relay, ctrl_q.mode};

endmodule
